/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque
// Operation and status codes, the input and result word layouts, and the
// default ring depth.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEQ_DEPTH = 16;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] POP_EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic               found;
    } t_out_word;

endpackage

/* rtl/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search: ring-buffer deque with a membership search
// Pushes and pops at either end of a DEPTH-entry ring memory, and answers
// whether a value is currently stored by scanning the occupied slots.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Word
//  -------   ---------  -------------------------  ----------------------
//  input     in         i_in_valid / o_in_ready    i_in_word  (t_in_word)
//  result    out        o_out_valid / i_out_ready  o_out_word (t_out_word)
//
// In a push or pop, the accept cycle issues the memory read, and S_EXEC then
// updates the pointers, writes the memory and loads the result once the output
// register is free. A query compares one entry per cycle through the single
// read port; on an empty queue it returns an all-zero result from S_EXEC.
// Reset (synchronous, active low) empties the queue; the ring memory itself
// is not cleared, since only slots that were written are ever read.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; a finished item holds its state until that register
// is free.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    // Wrapped slot: base + off modulo DEPTH, both operands below DEPTH.
    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[IW-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic signed [31:0] r_val, n_val;
    logic [IW-1:0]      r_front, n_front;
    logic [CW-1:0]      r_occ, n_occ;
    logic [IW-1:0]      r_scan_slot, n_scan_slot;
    logic [IW-1:0]      r_scan_cnt, n_scan_cnt;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    // Ring memory with a registered read port.
    logic [31:0]        r_mem [DEPTH];
    logic [31:0]        r_rd;
    logic               mem_we, mem_re;
    logic [IW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic               in_fire, out_free, q_full, q_empty;
    logic               scan_match, scan_last;
    logic [CW-1:0]      occ_dec;
    logic [IW-1:0]      front_dec, scan_next;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign q_full    = (r_occ >= DEPTH_C);
    assign q_empty   = (r_occ == '0);
    assign occ_dec   = r_occ - CW'(1);
    assign front_dec = (r_front == '0) ? LAST_SLOT : r_front - IW'(1);
    assign scan_next = (r_scan_slot == LAST_SLOT) ? '0 : r_scan_slot + IW'(1);
    assign scan_match = ($signed(r_rd) == r_val);
    assign scan_last  = ((CW'(r_scan_cnt) + CW'(1)) == r_occ);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_front     = r_front;
        n_occ       = r_occ;
        n_scan_slot = r_scan_slot;
        n_scan_cnt  = r_scan_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_front;
        mem_wdata   = r_val;
        mem_re      = 1'b0;
        mem_raddr   = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op    = i_in_word.operation;
                    n_val   = i_in_word.value;
                    n_state = S_EXEC;
                    unique case (i_in_word.operation)
                        OP_POP_FRONT: begin
                            mem_re    = 1'b1;
                            mem_raddr = r_front;
                        end
                        OP_POP_BACK: begin
                            mem_re    = 1'b1;
                            mem_raddr = f_slot(r_front, occ_dec[IW-1:0]);
                        end
                        OP_QUERY: begin
                            // Start the scan at the front slot.
                            mem_re      = 1'b1;
                            mem_raddr   = r_front;
                            n_scan_slot = r_front;
                            n_scan_cnt  = '0;
                            if (!q_empty) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_EXEC: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.popped_value = '0;
                    n_out.status       = ST_OK;
                    n_out.found        = 1'b0;
                    n_state            = S_IDLE;
                    unique case (r_op)
                        OP_PUSH_FRONT: begin
                            if (q_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = front_dec;
                                n_front   = front_dec;
                                n_occ     = r_occ + CW'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (q_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = f_slot(r_front, r_occ[IW-1:0]);
                                n_occ     = r_occ + CW'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (q_empty) begin
                                n_out.popped_value = POP_EMPTY_VALUE;
                                n_out.status       = ST_EMPTY;
                            end else begin
                                n_out.popped_value = $signed(r_rd);
                                n_front            = f_slot(r_front, IW'(1));
                                n_occ              = occ_dec;
                            end
                        end
                        OP_POP_BACK: begin
                            if (q_empty) begin
                                n_out.popped_value = POP_EMPTY_VALUE;
                                n_out.status       = ST_EMPTY;
                            end else begin
                                n_out.popped_value = $signed(r_rd);
                                n_occ              = occ_dec;
                            end
                        end
                        default: begin
                            // Query on an empty queue and unused codes: all zero.
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (scan_match || scan_last) begin
                    if (out_free) begin
                        n_out_valid        = 1'b1;
                        n_out.popped_value = '0;
                        n_out.status       = ST_OK;
                        n_out.found        = scan_match;
                        n_state            = S_IDLE;
                    end
                end else begin
                    mem_re      = 1'b1;
                    mem_raddr   = scan_next;
                    n_scan_slot = scan_next;
                    n_scan_cnt  = r_scan_cnt + IW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_val       <= n_val;
        r_scan_slot <= n_scan_slot;
        r_scan_cnt  <= n_scan_cnt;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

endmodule

/* dv/bounded_deque_with_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_tb: self-checking bench for the ring-buffer deque
// Drives push, pop, query and unused operation words through the valid/ready
// input channel. A behavioral deque tracks the expected contents and builds
// the expected result word for every accepted input word. A checker compares
// each result word, field by field, in order. Both channels idle in random
// bursts until the final stretch of the run.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_tb;
    import bdq_pkg::*;

    localparam int RING_DEPTH   = DEQ_DEPTH;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    // The slowest quiet stretch is a full-depth query scan behind the longest output
    // stall and the longest input gap. This limit is far above that.
    localparam int QUIET_LIMIT  = 3000;
    // A query on a full ring is the longest item; wait at least that long
    // after the last result before closing the run.
    localparam int DRAIN_CYCLES = 2 * RING_DEPTH + 8;

    // Operation codes 5 to 7 have no function and must leave the deque as is.
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    // Behavioral copy of the deque: ring contents, front slot and fill level.
    logic signed [31:0] ring_model [RING_DEPTH];
    int unsigned        front_model;
    int unsigned        count_model;

    // Result words that the deque still owes, oldest first.
    t_out_word   pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    // Random idling on both channels is enabled while this is set.
    bit          idle_on;

    bounded_deque_with_search #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral deque
    // ------------------------------------------------------------------------

    // Applies one accepted input word to the behavioral deque and queues the
    // result word that the block must return for it.
    function automatic void deque_model_apply(t_in_word w);
        t_out_word r;
        r        = '0;
        r.status = ST_OK;
        case (w.operation)
            OP_PUSH_FRONT: begin
                if (count_model == RING_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // The front slot steps back, wrapping below slot zero.
                    front_model             = (front_model + RING_DEPTH - 1) % RING_DEPTH;
                    ring_model[front_model] = w.value;
                    count_model++;
                end
            end
            OP_PUSH_BACK: begin
                if (count_model == RING_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_model[(front_model + count_model) % RING_DEPTH] = w.value;
                    count_model++;
                end
            end
            OP_POP_FRONT: begin
                if (count_model == 0) begin
                    r.popped_value = POP_EMPTY_VALUE;
                    r.status       = ST_EMPTY;
                end else begin
                    // Taking the last word leaves the front slot where it moved to.
                    r.popped_value = ring_model[front_model];
                    front_model    = (front_model + 1) % RING_DEPTH;
                    count_model--;
                end
            end
            OP_POP_BACK: begin
                if (count_model == 0) begin
                    r.popped_value = POP_EMPTY_VALUE;
                    r.status       = ST_EMPTY;
                end else begin
                    r.popped_value = ring_model[(front_model + count_model - 1) % RING_DEPTH];
                    count_model--;
                end
            end
            OP_QUERY: begin
                // Only occupied slots count, compared as full 32-bit patterns.
                for (int unsigned k = 0; k < count_model; k++) begin
                    if (ring_model[(front_model + k) % RING_DEPTH] == w.value) begin
                        r.found = 1'b1;
                    end
                end
            end
            default: begin
                // Unused codes return an all-zero result.
            end
        endcase
        pending_results.push_back(r);
    endfunction

    // A value that the behavioral deque holds right now; the deque must not be
    // empty when this is called.
    function automatic logic signed [31:0] stored_value();
        return ring_model[(front_model + $urandom_range(0, count_model - 1)) % RING_DEPTH];
    endfunction

    // Random 32-bit value with the extremes, -1 and a small range of repeats
    // mixed in, so that queries hit duplicates and boundary patterns.
    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 11))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return -32'sd1;
            3, 4:    return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------

    // Presents one word at a falling edge and holds it until the rising edge
    // that accepts it, then predicts its result. On return the bench sits at a
    // falling edge, so the next word can follow without a gap. A random gap,
    // when taken, drops valid and scrambles the idle payload.
    task automatic send_word(input logic [2:0] op, input logic signed [31:0] val);
        int unsigned gap;
        i_in_word.operation = op;
        i_in_word.value     = val;
        i_in_valid          = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        deque_model_apply(i_in_word);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap        = $urandom_range(1, 14);
            i_in_valid = 1'b0;
            i_in_word  = {3'($urandom), $urandom};
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: backpressure, checking and watchdog
    // ------------------------------------------------------------------------

    // The result channel alternates ready stretches and stalls of random length.
    // Stalls stop once idling is switched off.
    initial begin : result_backpressure
        int unsigned span;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                span        = $urandom_range(1, 14);
                i_out_ready = 1'b0;
            end else begin
                span        = $urandom_range(1, 30);
                i_out_ready = 1'b1;
            end
            repeat (span) @(negedge i_clk);
        end
    end

    // Prints one line per wrong field and counts it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Every accepted result word is matched against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending",
                                o_out_word.popped_value, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.popped_value !== want.popped_value) begin
                    report_mismatch("popped_value", o_out_word.popped_value,
                                    want.popped_value);
                end
                if (o_out_word.status !== want.status) begin
                    report_mismatch("status", o_out_word.status, want.status);
                end
                if (o_out_word.found !== want.found) begin
                    report_mismatch("found", o_out_word.found, want.found);
                end
            end
        end
    end

    // A hang shows up as a long run of cycles in which neither channel moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Pops and a query on the empty deque, pushes of the extreme values at
    // both ends with a wrap of the front slot, hit and miss queries, and
    // removal of the last word from either end.
    task automatic test_empty_and_ends();
        send_word(OP_POP_FRONT, random_value());
        send_word(OP_POP_BACK, random_value());
        send_word(OP_QUERY, 32'sd0);
        send_word(OP_PUSH_BACK, VALUE_MAX);
        send_word(OP_PUSH_FRONT, VALUE_MIN);
        send_word(OP_PUSH_BACK, 32'sd0);
        send_word(OP_PUSH_FRONT, -32'sd1);
        send_word(OP_QUERY, VALUE_MIN);
        send_word(OP_QUERY, -32'sd1);
        send_word(OP_QUERY, 32'sd1);
        send_word(OP_POP_BACK, random_value());
        send_word(OP_POP_FRONT, random_value());
        send_word(OP_POP_BACK, random_value());
        // The front pop below takes the only word left in the deque.
        send_word(OP_POP_FRONT, random_value());
        send_word(OP_PUSH_FRONT, 32'sh5A5A_A5A5);
        send_word(OP_POP_BACK, random_value());
        send_word(OP_POP_FRONT, random_value());
    endtask

    // Unused operation codes, sent while the deque holds a word.
    task automatic test_reserved_ops();
        send_word(OP_PUSH_BACK, random_value());
        for (int unsigned code = OP_RESERVED_LO; code <= OP_RESERVED_HI; code++) begin
            send_word(code[2:0], random_value());
        end
        send_word(OP_POP_FRONT, random_value());
    endtask

    // Fills the deque from both ends, pushes into the full deque at either
    // end, queries the full ring and then drains it past empty.
    task automatic test_fill_and_overflow();
        while (count_model < RING_DEPTH) begin
            send_word($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, random_value());
        end
        send_word(OP_PUSH_FRONT, random_value());
        send_word(OP_PUSH_BACK, random_value());
        send_word(OP_QUERY, stored_value());
        send_word(OP_QUERY, random_value());
        while (count_model > 0) begin
            send_word($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, random_value());
        end
        send_word(OP_POP_BACK, random_value());
    endtask

    // Random operations in phases of 48 words that lean toward filling,
    // draining or a balance, so the fill level sweeps between empty and full.
    // While the deque holds words, half of the queries look for a value that is stored.
    task automatic test_random_mix(input int unsigned n_words);
        int unsigned push_pct;
        int unsigned pop_pct;
        int unsigned pick;
        logic [2:0]  op;
        logic signed [31:0] val;
        push_pct = 40;
        pop_pct  = 35;
        for (int unsigned k = 0; k < n_words; k++) begin
            if (k % 48 == 0) begin
                case ($urandom_range(0, 2))
                    0:       begin push_pct = 65; pop_pct = 15; end
                    1:       begin push_pct = 20; pop_pct = 60; end
                    default: begin push_pct = 40; pop_pct = 35; end
                endcase
            end
            pick = $urandom_range(0, 99);
            val  = random_value();
            if (pick < push_pct) begin
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end else if (pick < push_pct + pop_pct) begin
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            end else if (pick < 97) begin
                op = OP_QUERY;
                if (count_model > 0 && $urandom_range(0, 1)) begin
                    val = stored_value();
                end
            end else begin
                op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
            end
            send_word(op, val);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        idle_on     = 1'b1;
        front_model = 0;
        count_model = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_ends();
        test_reserved_ops();
        test_fill_and_overflow();
        test_random_mix(1100);
        // The closing stretch runs with both channels always willing.
        idle_on = 1'b0;
        test_random_mix(200);
        i_in_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
